// ----- rtl/core/fosjq_pkg.sv -----
// shared types and constants for the fifo / shortest-job queue
package fosjq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int ID_W            = 32;
    localparam int LEN_W           = 32;
    localparam int OCC_W           = 7;
    localparam int CAP_W           = 7;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CAP_W-1:0] CAPACITY_RST = CAP_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY   = 2'd0,
        CFG_CAPACITY = 2'd1
    } t_cfg_idx;

    typedef enum logic {
        POL_FIFO = 1'b0,
        POL_SJN  = 1'b1
    } t_policy;

    typedef enum logic {
        MODE_ENQ = 1'b0,
        MODE_DEQ = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_FULL  = 2'd1,
        ST_DEQ   = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        t_mode             mode;
        logic [ID_W-1:0]   request_id;
        logic [LEN_W-1:0]  service_length;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   out_id;
        logic [LEN_W-1:0]  out_length;
        logic [OCC_W-1:0]  occupancy;
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  length;
    } t_entry;

endpackage

// ----- rtl/core/fosjq_mem.sv -----
// entry store: one write port, one registered read port
module fosjq_mem
    import fosjq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/fosjq_ctrl.sv -----
// queue sequencer: enqueue, scan for the pick, compaction
module fosjq_ctrl
    import fosjq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int PW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             o_busy,
    input  t_cmd             i_cmd,
    input  t_policy          i_policy,
    input  logic [CAP_W-1:0] i_capacity,
    output logic             o_strobe,
    output t_result          o_result,
    output logic             o_wr_en,
    output logic [PW-1:0]    o_wr_addr,
    output t_entry           o_wr_data,
    output logic             o_rd_en,
    output logic [PW-1:0]    o_rd_addr,
    input  t_entry           i_rd_data
);

    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [PW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_lim, n_lim;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [CW-1:0]     r_pend_off, n_pend_off;
    logic [CW-1:0]     r_pick, n_pick;
    logic [LEN_W-1:0]  r_min_len, n_min_len;
    logic [ID_W-1:0]   r_min_id, n_min_id;
    logic              r_strobe, n_strobe;
    t_result           r_result, n_result;

    logic              accept;
    logic              full;
    logic              issue;
    logic [CW-1:0]     cnt_dec;
    logic [LW-1:0]     cnt_ext;
    logic [LW-1:0]     dec_ext;
    logic [LW-1:0]     inc_ext;

    // (head + offset) mod depth, offset always below depth
    function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [PW:0] sum;
        sum = {1'b0, head} + {1'b0, off[PW-1:0]};
        if (sum >= (PW+1)'(DEPTH)) begin
            sum = sum - (PW+1)'(DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    assign accept  = start && (r_state == S_IDLE);
    assign cnt_ext = LW'(r_count);
    // full when count reaches the capacity or the store depth
    assign full    = (cnt_ext >= LW'(i_capacity)) || (r_count >= CW'(DEPTH));
    assign cnt_dec = r_count - CW'(1);
    assign dec_ext = LW'(cnt_dec);
    assign inc_ext = LW'(r_count + CW'(1));

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_head     = r_head;
        n_lim      = r_lim;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_pend_off = r_pend_off;
        n_pick     = r_pick;
        n_min_len  = r_min_len;
        n_min_id   = r_min_id;
        n_strobe   = 1'b0;
        n_result   = r_result;
        o_wr_en    = 1'b0;
        o_wr_addr  = slot_of(r_head, r_count);
        o_wr_data  = '{id: i_cmd.request_id, length: i_cmd.service_length};
        o_rd_en    = 1'b0;
        o_rd_addr  = slot_of(r_head, r_idx);
        issue      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.mode == MODE_ENQ) begin
                        n_strobe = 1'b1;
                        if (full) begin
                            n_result = '{status: ST_FULL, out_id: i_cmd.request_id,
                                         out_length: '0, occupancy: cnt_ext[OCC_W-1:0]};
                        end else begin
                            o_wr_en  = 1'b1;
                            n_count  = r_count + CW'(1);
                            n_result = '{status: ST_ENQ, out_id: '0, out_length: '0,
                                         occupancy: inc_ext[OCC_W-1:0]};
                        end
                    end else if (r_count == '0) begin
                        n_strobe = 1'b1;
                        n_result = '{status: ST_EMPTY, out_id: '0, out_length: '0,
                                     occupancy: '0};
                    end else begin
                        n_state = S_SCAN;
                        n_idx   = '0;
                        n_pick  = '0;
                        n_lim   = (i_policy == POL_SJN) ? r_count : CW'(1);
                    end
                end
            end

            S_SCAN: begin
                issue      = (r_idx < r_lim);
                o_rd_en    = issue;
                n_pend     = issue;
                n_pend_off = r_idx;
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end
                // strict less keeps the earliest arrival on ties
                if (r_pend && ((r_pend_off == '0) || (i_rd_data.length < r_min_len))) begin
                    n_min_len = i_rd_data.length;
                    n_min_id  = i_rd_data.id;
                    n_pick    = r_pend_off;
                end
                if (!issue && !r_pend) begin
                    if (r_pick == '0) begin
                        n_state  = S_IDLE;
                        n_count  = cnt_dec;
                        n_head   = (cnt_dec == '0) ? '0 : slot_of(r_head, CW'(1));
                        n_strobe = 1'b1;
                        n_result = '{status: ST_DEQ, out_id: r_min_id,
                                     out_length: r_min_len, occupancy: dec_ext[OCC_W-1:0]};
                    end else begin
                        n_state = S_SHIFT;
                        n_idx   = r_pick + CW'(1);
                    end
                end
            end

            S_SHIFT: begin
                // read offset k+1, write it back one place lower
                issue      = (r_idx < r_count);
                o_rd_en    = issue;
                n_pend     = issue;
                n_pend_off = r_idx;
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = slot_of(r_head, r_pend_off - CW'(1));
                    o_wr_data = i_rd_data;
                end
                if (!issue && !r_pend) begin
                    n_state  = S_IDLE;
                    n_count  = cnt_dec;
                    n_head   = (cnt_dec == '0) ? '0 : r_head;
                    n_strobe = 1'b1;
                    n_result = '{status: ST_DEQ, out_id: r_min_id,
                                 out_length: r_min_len, occupancy: dec_ext[OCC_W-1:0]};
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_head   <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_head   <= n_head;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
        r_lim      <= n_lim;
        r_idx      <= n_idx;
        r_pend_off <= n_pend_off;
        r_pick     <= n_pick;
        r_min_len  <= n_min_len;
        r_min_id   <= n_min_id;
        r_result   <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above store depth");

    a_deq_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.status == ST_DEQ) |-> (r_count == $past(r_count) - CW'(1)))
        else $error("dequeue did not drop the count by one");

    a_enq_prompt : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_result.status == ST_ENQ || r_result.status == ST_FULL))
            |-> $past(start && !o_busy))
        else $error("enqueue result without a command the cycle before");

    a_empty_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.status == ST_EMPTY)
            |-> (r_count == '0 && r_result.out_id == '0 && r_result.out_length == '0))
        else $error("empty result with live entries or payload");

endmodule

// ----- rtl/core/fifo_or_shortest_job_queue.sv -----
// top level of the bounded request queue, fifo or shortest job next
// usage
//   command channel: drive i_cmd and raise start; the command transfer
//   happens at a clock edge with start high and busy low
//   result channel: o_strobe is high for exactly one cycle with o_result;
//   the receiver cannot stall, every result is taken in that cycle
//   config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; index 0 is the policy (0 fifo, 1 shortest job next),
//   index 1 the capacity (7 bits, clipped to the store depth); o_cfg_ready
//   is always high, write only while the queue is idle
// timing
//   enqueue, rejection and dequeue from empty: result registered in the cycle
//   after the command transfer, busy stays low so commands may follow every cycle
//   fifo dequeue: only the head entry is read, no gap to close
//   shortest job dequeue: a scan of all the lengths through the single
//   read port, then, unless the pick is the head, a shift of the entries
//   behind it one place lower to close the gap; the registered read of
//   the entry store sets the pace of both sweeps
// reset
//   synchronous, active low: queue empty, head at slot 0, policy fifo,
//   capacity 64; the entry store itself is not cleared
module fifo_or_shortest_job_queue
    import fosjq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_cmd                  i_cmd,
    output logic                  o_strobe,
    output t_result               o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_policy          r_policy;
    logic [CAP_W-1:0] r_capacity;

    // store port wiring
    logic             wr_en;
    logic [PW-1:0]    wr_addr;
    t_entry           wr_data;
    logic             rd_en;
    logic [PW-1:0]    rd_addr;
    t_entry           rd_data;

    // config registers, always ready; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= POL_FIFO;
            r_capacity <= CAPACITY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_POLICY:   r_policy   <= t_policy'(i_cfg_data[0]);
                CFG_CAPACITY: r_capacity <= i_cfg_data[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer owns count, head and the result register
    fosjq_ctrl #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .o_busy     (busy),
        .i_cmd      (i_cmd),
        .i_policy   (r_policy),
        .i_capacity (r_capacity),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    // circular entry store, ids and lengths side by side
    fosjq_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
